// ===== rtl/core/power_key_backlight_idle_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// Power key backlight idle controller: assertion macros
// Shared macros for the concurrent checks on the controller's ports.
// ----------------------------------------------------------------------------
`ifndef POWER_KEY_BACKLIGHT_IDLE_CONTROLLER_CORE_ASSERT_SVH
`define POWER_KEY_BACKLIGHT_IDLE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PKBIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PKBIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pkbic_pkg.sv =====
// ----------------------------------------------------------------------------
// Power key backlight idle controller: package
// Types and codes shared by the controller's modules.
// ----------------------------------------------------------------------------
package pkbic_pkg;

    localparam int LEVEL_W = 16;
    localparam int COUNT_W = 16;

    // Item kinds.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Event classes; every other code is ignored.
    localparam logic [2:0] EV_SYNC = 3'd0;
    localparam logic [2:0] EV_KEY  = 3'd1;
    localparam logic [2:0] EV_ABS  = 3'd2;
    localparam logic [2:0] EV_REL  = 3'd3;

    // Key identifiers.
    localparam logic [1:0] KEY_OTHER    = 2'd0;
    localparam logic [1:0] KEY_PWR      = 2'd1;
    localparam logic [1:0] KEY_VOL_UP   = 2'd2;
    localparam logic [1:0] KEY_VOL_DOWN = 2'd3;

    // Key actions.
    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_REPEAT  = 2'd2;

    // Font step requests.
    localparam logic [1:0] FONT_NONE = 2'd0;
    localparam logic [1:0] FONT_UP   = 2'd1;
    localparam logic [1:0] FONT_DOWN = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 3'd4;

    // Reset values.
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL  = 16'd2047;
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL  = 16'd20;
    localparam logic [COUNT_W-1:0] RST_IDLE_LIMIT = 16'd300;
    localparam logic [COUNT_W-1:0] RST_HOLD_LIMIT = 16'd8;
    localparam logic [LEVEL_W-1:0] RST_LEVEL      = 16'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic               present;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] min_level;
        logic [COUNT_W-1:0] idle_limit;
        logic [COUNT_W-1:0] hold_limit;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [2:0] event_class;
        logic [1:0] key_id;
        logic [1:0] key_action;
        logic       from_touch;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] current_level;
        logic [LEVEL_W-1:0] saved_level;
        logic               is_dimmed;
        logic               power_held;
        logic [COUNT_W-1:0] hold_count;
        logic [COUNT_W-1:0] idle_count;
    } state_t;

    typedef struct packed {
        logic               level_write;
        logic [LEVEL_W-1:0] level_value;
        logic               power_off;
        logic [1:0]         font_step;
        logic               screen_off;
    } result_t;

endpackage

// ===== rtl/core/pkbic_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Power key backlight idle controller: configuration registers
// Holds the five control registers written through the plain write port.
// ----------------------------------------------------------------------------
module pkbic_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pkbic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pkbic_pkg::LEVEL_W-1:0]     cfg_data,
    output pkbic_pkg::cfg_t                   cfg
);
    import pkbic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESENT:    cfg_next.present    = cfg_data[0];
                CFG_MAX_LEVEL:  cfg_next.max_level  = cfg_data;
                CFG_MIN_LEVEL:  cfg_next.min_level  = cfg_data;
                CFG_IDLE_LIMIT: cfg_next.idle_limit = cfg_data;
                CFG_HOLD_LIMIT: cfg_next.hold_limit = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.present    <= 1'b1;
            cfg_reg.max_level  <= RST_MAX_LEVEL;
            cfg_reg.min_level  <= RST_MIN_LEVEL;
            cfg_reg.idle_limit <= RST_IDLE_LIMIT;
            cfg_reg.hold_limit <= RST_HOLD_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/pkbic_step.sv =====
// ----------------------------------------------------------------------------
// Power key backlight idle controller: item step logic
// Combinational next state and result for one tick or input event.
// ----------------------------------------------------------------------------
module pkbic_step (
    input  pkbic_pkg::cfg_t    cfg,
    input  pkbic_pkg::state_t  st,
    input  pkbic_pkg::item_t   item,
    output pkbic_pkg::state_t  st_next,
    output pkbic_pkg::result_t res
);
    import pkbic_pkg::*;

    logic [COUNT_W-1:0] idle_inc;
    logic [COUNT_W-1:0] hold_inc;
    logic [LEVEL_W-1:0] clamp_max;
    logic [LEVEL_W-1:0] restore_level;
    logic               want_dim;
    logic               want_restore;
    logic               active_event;

    assign idle_inc = (st.idle_count == COUNT_MAX) ? COUNT_MAX : st.idle_count + 1'b1;
    assign hold_inc = (st.hold_count == COUNT_MAX) ? COUNT_MAX : st.hold_count + 1'b1;

    // Saved level clamped to max first, then min, so min wins on a conflict.
    assign clamp_max     = (st.saved_level > cfg.max_level) ? cfg.max_level : st.saved_level;
    assign restore_level = (clamp_max < cfg.min_level) ? cfg.min_level : clamp_max;

    assign active_event = (item.event_class == EV_KEY) || (item.event_class == EV_ABS)
                       || (item.event_class == EV_REL);

    always_comb
    begin
        st_next         = st;
        res.level_write = 1'b0;
        res.level_value = '0;
        res.power_off   = 1'b0;
        res.font_step   = FONT_NONE;
        want_dim        = 1'b0;
        want_restore    = 1'b0;

        if (item.op == OP_TICK)
        begin
            st_next.idle_count = idle_inc;
            if (st.power_held)
            begin
                st_next.hold_count = hold_inc;
                if ((cfg.hold_limit != '0) && (hold_inc >= cfg.hold_limit))
                begin
                    res.power_off      = 1'b1;
                    st_next.power_held = 1'b0;
                end
            end
            want_dim = (cfg.idle_limit != '0) && !st.is_dimmed
                    && (idle_inc >= cfg.idle_limit);
        end
        else if (active_event)
        begin
            st_next.idle_count = '0;
            if (item.from_touch)
            begin
                want_restore = 1'b1;
            end
            else if (item.event_class == EV_KEY)
            begin
                if (item.key_id == KEY_PWR)
                begin
                    if (item.key_action == ACT_PRESS)
                    begin
                        st_next.power_held = 1'b1;
                        st_next.hold_count = '0;
                    end
                    else if ((item.key_action == ACT_RELEASE) && st.power_held)
                    begin
                        st_next.power_held = 1'b0;
                        if (st.hold_count < cfg.hold_limit)
                        begin
                            want_restore = st.is_dimmed;
                            want_dim     = !st.is_dimmed;
                        end
                    end
                end
                else if ((item.key_action == ACT_PRESS) && (item.key_id == KEY_VOL_UP))
                begin
                    want_restore  = 1'b1;
                    res.font_step = FONT_UP;
                end
                else if ((item.key_action == ACT_PRESS) && (item.key_id == KEY_VOL_DOWN))
                begin
                    want_restore  = 1'b1;
                    res.font_step = FONT_DOWN;
                end
            end
        end

        // Dim and restore never both fire for one item.
        if (want_dim && cfg.present && !st.is_dimmed)
        begin
            st_next.saved_level   = (st.current_level > cfg.min_level) ? st.current_level
                                                                       : cfg.max_level;
            st_next.is_dimmed     = 1'b1;
            st_next.current_level = '0;
            res.level_write       = 1'b1;
        end
        else if (want_restore && cfg.present && st.is_dimmed)
        begin
            st_next.is_dimmed = 1'b0;
            if (restore_level != st.current_level)
            begin
                st_next.current_level = restore_level;
                res.level_write       = 1'b1;
                res.level_value       = restore_level;
            end
        end

        res.screen_off = st_next.is_dimmed;
    end

endmodule

// ===== rtl/core/power_key_backlight_idle_controller_core.sv =====
// ----------------------------------------------------------------------------
// Power key backlight idle controller
// Tracks backlight level, dimming, power key hold time and idle time.
// ----------------------------------------------------------------------------
// A result word is computed from the item held in the input register and
// is loaded into the result register when that item advances.
// Throughput: one item per cycle while the result channel is not stalled;
// the combinational step logic between the two registers settles the whole item, including the state update.
// Reset: rst_n clears the valid flags, the controller state and the
// configuration registers to their documented values at once.
module power_key_backlight_idle_controller_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [pkbic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pkbic_pkg::LEVEL_W-1:0]   cfg_data,
    // Input channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [2:0]                      event_class,
    input  logic [1:0]                      key_id,
    input  logic [1:0]                      key_action,
    input  logic                            from_touch,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            level_write,
    output logic [pkbic_pkg::LEVEL_W-1:0]   level_value,
    output logic                            power_off,
    output logic [1:0]                      font_step,
    output logic                            screen_off
);
    import pkbic_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_next;
    logic    item_valid_reg;
    logic    item_valid_next;
    state_t  state_reg;
    state_t  state_step;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    result_t result_step;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    in_take;
    logic    advance;

    pkbic_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pkbic_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_step),
        .res     (result_step)
    );

    // The held item moves on whenever the result register is empty or is
    // being drained this cycle. The state is committed on that same edge,
    // so the following item sees it straight away.
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_next       = in_take ? item_t'{op, event_class, key_id, key_action, from_touch}
                                  : item_reg;
        item_valid_next = in_take || (item_valid_reg && !advance);
        state_next      = advance ? state_step : state_reg;
        result_next     = advance ? result_step : result_reg;
        out_valid_next  = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg          <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.current_level <= RST_LEVEL;
            state_reg.saved_level   <= RST_LEVEL;
            state_reg.is_dimmed     <= 1'b0;
            state_reg.power_held    <= 1'b0;
            state_reg.hold_count    <= '0;
            state_reg.idle_count    <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign level_write = result_reg.level_write;
    assign level_value = result_reg.level_value;
    assign power_off   = result_reg.power_off;
    assign font_step   = result_reg.font_step;
    assign screen_off  = result_reg.screen_off;

endmodule

// ===== rtl/core/pkbic_checker.sv =====
// ----------------------------------------------------------------------------
// Power key backlight idle controller: port checker
// Concurrent checks on the controller's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "power_key_backlight_idle_controller_core_assert.svh"

module pkbic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        level_write,
    input logic [15:0] level_value,
    input logic        power_off,
    input logic [1:0]  font_step,
    input logic        screen_off
);
    import pkbic_pkg::*;

    // A stalled word stays in place unchanged.
    `PKBIC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(level_value) && $stable(screen_off) && $stable(level_write), "stalled result word changed")

    // A written level of zero is a dim, anything else is a restore.
    `PKBIC_ASSERT_IMP(a_dim_zero, clk, rst_n, out_valid && level_write && (level_value == 16'd0), screen_off, "zero level written while screen is on")

    `PKBIC_ASSERT_IMP(a_restore_on, clk, rst_n, out_valid && level_write && (level_value != 16'd0), !screen_off, "nonzero level written while screen is dimmed")

    // Font steps come from key events and poweroff only from ticks.
    `PKBIC_ASSERT_IMP(a_font_tick, clk, rst_n, out_valid && (font_step != FONT_NONE), !power_off && ((font_step == FONT_UP) || (font_step == FONT_DOWN)), "font step together with poweroff or bad code")

endmodule

bind power_key_backlight_idle_controller_core pkbic_checker u_pkbic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level_write (level_write),
    .level_value (level_value),
    .power_off   (power_off),
    .font_step   (font_step),
    .screen_off  (screen_off)
);
